>>> hdl/dcmts_pkg.sv
// Shared types, constants and helpers of the DC motor torque step block.
package dcmts_pkg;

    localparam int DATA_W  = 32;
    localparam int REG_W   = 31;
    localparam int CMD_W   = 18;
    localparam int SLEW_W  = 17;
    localparam int IDX_W   = 3;
    localparam int PROD_W  = 64;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_GEAR_RATIO     = 3'd0;
    localparam logic [IDX_W-1:0] REG_MOTOR_CONSTANT = 3'd1;
    localparam logic [IDX_W-1:0] REG_WINDING_RES    = 3'd2;
    localparam logic [IDX_W-1:0] REG_VISCOUS_COEFF  = 3'd3;
    localparam logic [IDX_W-1:0] REG_FRICTION       = 3'd4;
    localparam logic [IDX_W-1:0] REG_SLEW           = 3'd5;

    localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_W,
        ST_MUL_P1,
        ST_MUL_UK,
        ST_MUL_UG,
        ST_DIFF,
        ST_DIV,
        ST_MUL_A,
        ST_MUL_B,
        ST_VISC,
        ST_FRIC,
        ST_MUL_T,
        ST_MUL_CUR,
        ST_DONE
    } seq_state_t;

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_RUN,
        DV_FIN
    } div_state_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] a;
        logic signed [DATA_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic                     start;
        logic signed [DATA_W-1:0] dividend;
        logic [REG_W-1:0]         divisor;
    } div_req_t;

    typedef struct packed {
        logic                     done;
        logic signed [DATA_W-1:0] quotient;
    } div_rsp_t;

    // Saturate a wide signed value to the signed 32 bit range.
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] x);
        logic signed [DATA_W-1:0] r;
        if (x > 64'sh0000_0000_7FFF_FFFF)
        begin
            r = S32_MAX;
        end
        else if (x < -64'sh0000_0000_8000_0000)
        begin
            r = S32_MIN;
        end
        else
        begin
            r = x[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

>>> hdl/dcmts_item_if.sv
// Request channel carrying one simulation tick into the block.
interface dcmts_item_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [dcmts_pkg::DATA_W-1:0]    shaft_speed;
    logic [dcmts_pkg::REG_W-1:0]            battery_voltage;
    logic signed [dcmts_pkg::CMD_W-1:0]     throttle_cmd;

    modport source (output valid, output shaft_speed, output battery_voltage,
                    output throttle_cmd, input ready);
    modport sink (input valid, input shaft_speed, input battery_voltage,
                  input throttle_cmd, output ready);
endinterface

>>> hdl/dcmts_result_if.sv
// Result channel carrying the torque, battery current and throttle level.
interface dcmts_result_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [dcmts_pkg::DATA_W-1:0]    torque_out;
    logic [dcmts_pkg::REG_W-1:0]            battery_current;
    logic signed [dcmts_pkg::CMD_W-1:0]     throttle_level;

    modport source (output valid, output torque_out, output battery_current,
                    output throttle_level, input ready);
    modport sink (input valid, input torque_out, input battery_current,
                  input throttle_level, output ready);
endinterface

>>> hdl/dcmts_mul.sv
// Shared fixed point multiplier with a product register, floor shift and saturation.
module dcmts_mul #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                clk,
    input  dcmts_pkg::mul_req_t                 req,
    output logic signed [dcmts_pkg::DATA_W-1:0] res
);

    logic signed [dcmts_pkg::PROD_W-1:0] prod_reg;
    logic signed [dcmts_pkg::PROD_W-1:0] prod_next;

    assign prod_next = $signed(req.a) * $signed(req.b);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    // The arithmetic shift rounds toward minus infinity.
    assign res = dcmts_pkg::sat32(prod_reg >>> FRAC_BITS);

endmodule

>>> hdl/dcmts_div.sv
// Restoring divider for (dividend * 2^FRAC_BITS) / divisor, truncated and saturated.
module dcmts_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  dcmts_pkg::div_req_t req,
    output dcmts_pkg::div_rsp_t rsp
);

    localparam int DW = dcmts_pkg::DATA_W;

    dcmts_pkg::div_state_t st_reg, st_next;
    logic [DW-1:0]         rem_reg, rem_next;
    logic [DW-1:0]         q_reg, q_next;
    logic [4:0]            cnt_reg, cnt_next;
    logic                  neg_reg, neg_next;
    logic signed [DW-1:0]  res_reg, res_next;

    logic [DW-1:0]         mag;
    logic [DW-1:0]         upper;
    logic [DW-1:0]         lower;
    logic                  ovf;
    logic [DW:0]           trial;
    logic [DW:0]           trial_sub;
    logic                  ge;
    logic [DW-1:0]         q_fin;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= dcmts_pkg::DV_IDLE;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        cnt_reg <= cnt_next;
        neg_reg <= neg_next;
        res_reg <= res_next;
    end

    always_comb
    begin
        // Magnitude of the dividend; the scaled dividend is mag followed by FRAC_BITS zeros.
        mag   = req.dividend[DW-1] ? (~req.dividend + 32'd1) : req.dividend;
        upper = {{(DW-FRAC_BITS){1'b0}}, mag[DW-1:DW-FRAC_BITS]};
        lower = {mag[DW-1-FRAC_BITS:0], {FRAC_BITS{1'b0}}};
        // A quotient of 2^32 or more saturates either way.
        ovf   = upper >= {1'b0, req.divisor};

        trial     = {rem_reg, q_reg[DW-1]};
        ge        = trial >= {2'b00, req.divisor};
        trial_sub = trial - {2'b00, req.divisor};
        q_fin     = {q_reg[DW-2:0], ge};

        st_next  = st_reg;
        rem_next = rem_reg;
        q_next   = q_reg;
        cnt_next = cnt_reg;
        neg_next = neg_reg;
        res_next = res_reg;

        case (st_reg)
            dcmts_pkg::DV_IDLE:
            begin
                if (req.start)
                begin
                    neg_next = req.dividend[DW-1];
                    if (req.dividend == '0)
                    begin
                        res_next = '0;
                        st_next  = dcmts_pkg::DV_FIN;
                    end
                    else if (ovf)
                    begin
                        res_next = req.dividend[DW-1] ? dcmts_pkg::S32_MIN : dcmts_pkg::S32_MAX;
                        st_next  = dcmts_pkg::DV_FIN;
                    end
                    else
                    begin
                        rem_next = upper;
                        q_next   = lower;
                        cnt_next = 5'd31;
                        st_next  = dcmts_pkg::DV_RUN;
                    end
                end
            end
            dcmts_pkg::DV_RUN:
            begin
                rem_next = ge ? trial_sub[DW-1:0] : trial[DW-1:0];
                q_next   = q_fin;
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                begin
                    if (neg_reg)
                    begin
                        res_next = (q_fin > 32'h8000_0000) ? dcmts_pkg::S32_MIN
                                                          : $signed(~q_fin + 32'd1);
                    end
                    else
                    begin
                        res_next = q_fin[DW-1] ? dcmts_pkg::S32_MAX : $signed(q_fin);
                    end
                    st_next = dcmts_pkg::DV_FIN;
                end
            end
            dcmts_pkg::DV_FIN:
            begin
                st_next = dcmts_pkg::DV_IDLE;
            end
            default:
            begin
                st_next = dcmts_pkg::DV_IDLE;
            end
        endcase
    end

    assign rsp.done     = (st_reg == dcmts_pkg::DV_FIN);
    assign rsp.quotient = res_reg;

endmodule

>>> hdl/dc_motor_torque_step.sv
// Top level of the brushed DC motor torque step: sequencer, registers and result stage.
// The divide takes 32 divider steps, and is skipped when it saturates or its dividend is zero;
// a stalled result side adds its stall. A new request is accepted only while the sequencer
// is idle, so the radix-2 divider is through with one request before the next comes; a
// finished result waits in the output register while the next request is accepted.
// Reset (rst_n, asynchronous, active low) clears level, sequencer and valid; config takes defaults.
module dc_motor_torque_step #(
    parameter int FRAC_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    dcmts_item_if.sink                      item,
    dcmts_result_if.source                  result,
    input  logic                            cfg_we,
    input  logic [dcmts_pkg::IDX_W-1:0]     cfg_index,
    input  logic [dcmts_pkg::REG_W-1:0]     cfg_data
);

    localparam int DW = dcmts_pkg::DATA_W;
    localparam int RW = dcmts_pkg::REG_W;
    localparam int CW = dcmts_pkg::CMD_W;
    localparam int SW = dcmts_pkg::SLEW_W;

    // Fixed point constants: one, efficiency 0.95 rounded to nearest, and the
    // smallest battery voltage that is not under 0.01 V.
    localparam longint ONE_L  = 64'sd1 <<< FRAC_BITS;
    localparam longint ETA_L  = (95 * ONE_L + 50) / 100;
    localparam longint VLOW_L = (ONE_L + 99) / 100;
    localparam logic signed [DW-1:0] ONE_Q  = DW'(ONE_L);
    localparam logic signed [DW-1:0] ETA_Q  = DW'(ETA_L);
    localparam logic [RW-1:0]        VLOW_Q = RW'(VLOW_L);

    // Configuration registers.
    logic [RW-1:0] gear_reg;
    logic [RW-1:0] kt_reg;
    logic [RW-1:0] res_ohm_reg;
    logic [RW-1:0] visc_reg;
    logic [RW-1:0] fric_reg;
    logic [SW-1:0] slew_reg;

    // Sequencer and datapath registers.
    dcmts_pkg::seq_state_t    st_reg, st_next;
    logic signed [CW-1:0]     lvl_reg, lvl_next;
    logic signed [DW-1:0]     speed_reg, speed_next;
    logic [RW-1:0]            volt_reg, volt_next;
    logic signed [DW-1:0]     w_reg, w_next;
    logic signed [DW-1:0]     uk_reg, uk_next;
    logic signed [DW-1:0]     im_reg, im_next;
    logic signed [DW-1:0]     mm_reg, mm_next;
    logic signed [DW-1:0]     torque_reg, torque_next;

    // Output register.
    logic                     out_valid_reg, out_valid_next;
    logic signed [DW-1:0]     out_torque_reg, out_torque_next;
    logic [RW-1:0]            out_cur_reg, out_cur_next;
    logic signed [CW-1:0]     out_lvl_reg, out_lvl_next;

    dcmts_pkg::mul_req_t      mul_req;
    logic signed [DW-1:0]     mul_res;
    dcmts_pkg::div_req_t      div_req;
    dcmts_pkg::div_rsp_t      div_rsp;

    // Slew limiter signals.
    logic                     accept;
    logic signed [DW-1:0]     cmd_wide;
    logic signed [CW-1:0]     target;
    logic signed [CW+1:0]     lvl_wide;
    logic signed [CW+1:0]     tgt_wide;
    logic signed [CW+1:0]     lvl_up;
    logic signed [CW+1:0]     lvl_dn;
    logic signed [CW+1:0]     lvl_slewed;

    logic signed [DW-1:0]     gear_s;
    logic signed [DW-1:0]     kt_s;
    logic signed [DW-1:0]     visc_s;
    logic signed [DW-1:0]     fric_s;
    logic                     out_free;

    assign gear_s = $signed({1'b0, gear_reg});
    assign kt_s   = $signed({1'b0, kt_reg});
    assign visc_s = $signed({1'b0, visc_reg});
    assign fric_s = $signed({1'b0, fric_reg});

    dcmts_mul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .clk (clk),
        .req (mul_req),
        .res (mul_res)
    );

    dcmts_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gear_reg    <= 31'd65536;
            kt_reg      <= 31'd655;
            res_ohm_reg <= 31'd6554;
            visc_reg    <= 31'd0;
            fric_reg    <= 31'd0;
            slew_reg    <= 17'd196;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dcmts_pkg::REG_GEAR_RATIO:     gear_reg    <= cfg_data;
                dcmts_pkg::REG_MOTOR_CONSTANT: kt_reg      <= cfg_data;
                dcmts_pkg::REG_WINDING_RES:    res_ohm_reg <= cfg_data;
                dcmts_pkg::REG_VISCOUS_COEFF:  visc_reg    <= cfg_data;
                dcmts_pkg::REG_FRICTION:       fric_reg    <= cfg_data;
                dcmts_pkg::REG_SLEW:           slew_reg    <= cfg_data[SW-1:0];
                default:                       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= dcmts_pkg::ST_IDLE;
            lvl_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            lvl_reg       <= lvl_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        speed_reg      <= speed_next;
        volt_reg       <= volt_next;
        w_reg          <= w_next;
        uk_reg         <= uk_next;
        im_reg         <= im_next;
        mm_reg         <= mm_next;
        torque_reg     <= torque_next;
        out_torque_reg <= out_torque_next;
        out_cur_reg    <= out_cur_next;
        out_lvl_reg    <= out_lvl_next;
    end

    // The new throttle level is worked out from the request fields as it is accepted.
    // The command is clamped at one from above only, then the level moves toward it
    // by at most the slew step without passing it.
    always_comb
    begin
        cmd_wide = DW'(item.throttle_cmd);
        target   = (cmd_wide > ONE_Q) ? ONE_Q[CW-1:0] : item.throttle_cmd;
        lvl_wide = (CW+2)'(lvl_reg);
        tgt_wide = (CW+2)'(target);
        lvl_up   = lvl_wide + $signed({3'b000, slew_reg});
        lvl_dn   = lvl_wide - $signed({3'b000, slew_reg});
        if (lvl_wide < tgt_wide)
        begin
            lvl_slewed = (lvl_up > tgt_wide) ? tgt_wide : lvl_up;
        end
        else
        begin
            lvl_slewed = (lvl_dn < tgt_wide) ? tgt_wide : lvl_dn;
        end
    end

    assign item.ready = (st_reg == dcmts_pkg::ST_IDLE);
    assign accept     = item.valid && item.ready;
    assign out_free   = !out_valid_reg || result.ready;

    // Sequencer. Each multiply state drives the shared multiplier; its saturated
    // result appears in the cycle after and is picked up by the following state.
    always_comb
    begin
        st_next         = st_reg;
        lvl_next        = lvl_reg;
        speed_next      = speed_reg;
        volt_next       = volt_reg;
        w_next          = w_reg;
        uk_next         = uk_reg;
        im_next         = im_reg;
        mm_next         = mm_reg;
        torque_next     = torque_reg;
        out_torque_next = out_torque_reg;
        out_cur_next    = out_cur_reg;
        out_lvl_next    = out_lvl_reg;
        out_valid_next  = out_valid_reg && !result.ready;

        // The idle operands keep the battery current product steady while a
        // result waits for the output register.
        mul_req.a = im_reg;
        mul_req.b = DW'(lvl_reg);

        div_req.start    = 1'b0;
        div_req.dividend = mm_reg;
        div_req.divisor  = res_ohm_reg;

        case (st_reg)
            dcmts_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    speed_next = item.shaft_speed;
                    volt_next  = item.battery_voltage;
                    // An empty battery forces the level to zero and ignores the command.
                    if (item.battery_voltage < VLOW_Q)
                    begin
                        lvl_next = '0;
                    end
                    else
                    begin
                        lvl_next = lvl_slewed[CW-1:0];
                    end
                    st_next = dcmts_pkg::ST_MUL_W;
                end
            end
            dcmts_pkg::ST_MUL_W:
            begin
                // Motor speed from the shaft speed and the gear ratio.
                mul_req.a = gear_s;
                mul_req.b = speed_reg;
                st_next   = dcmts_pkg::ST_MUL_P1;
            end
            dcmts_pkg::ST_MUL_P1:
            begin
                w_next    = mul_res;
                mul_req.a = DW'(lvl_reg);
                mul_req.b = $signed({1'b0, volt_reg});
                st_next   = dcmts_pkg::ST_MUL_UK;
            end
            dcmts_pkg::ST_MUL_UK:
            begin
                // Motor voltage: level times battery voltage times efficiency.
                mul_req.a = mul_res;
                mul_req.b = ETA_Q;
                st_next   = dcmts_pkg::ST_MUL_UG;
            end
            dcmts_pkg::ST_MUL_UG:
            begin
                // Back-emf from the motor speed.
                uk_next   = mul_res;
                mul_req.a = w_reg;
                mul_req.b = kt_s;
                st_next   = dcmts_pkg::ST_DIFF;
            end
            dcmts_pkg::ST_DIFF:
            begin
                // The voltage difference across the winding goes to the divider.
                div_req.start    = 1'b1;
                div_req.dividend = dcmts_pkg::sat32(64'(uk_reg) - 64'(mul_res));
                st_next          = dcmts_pkg::ST_DIV;
            end
            dcmts_pkg::ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    im_next = div_rsp.quotient;
                    st_next = dcmts_pkg::ST_MUL_A;
                end
            end
            dcmts_pkg::ST_MUL_A:
            begin
                mul_req.a = kt_s;
                mul_req.b = im_reg;
                st_next   = dcmts_pkg::ST_MUL_B;
            end
            dcmts_pkg::ST_MUL_B:
            begin
                mm_next   = mul_res;
                mul_req.a = visc_s;
                mul_req.b = w_reg;
                st_next   = dcmts_pkg::ST_VISC;
            end
            dcmts_pkg::ST_VISC:
            begin
                // Motor torque less viscous friction.
                mm_next = dcmts_pkg::sat32(64'(mm_reg) - 64'(mul_res));
                st_next = dcmts_pkg::ST_FRIC;
            end
            dcmts_pkg::ST_FRIC:
            begin
                // Coulomb friction opposes rotation; a standing motor counts as reversing.
                if (w_reg > 0)
                begin
                    mm_next = dcmts_pkg::sat32(64'(mm_reg) - 64'(fric_s));
                end
                else
                begin
                    mm_next = dcmts_pkg::sat32(64'(mm_reg) + 64'(fric_s));
                end
                st_next = dcmts_pkg::ST_MUL_T;
            end
            dcmts_pkg::ST_MUL_T:
            begin
                mul_req.a = mm_reg;
                mul_req.b = gear_s;
                st_next   = dcmts_pkg::ST_MUL_CUR;
            end
            dcmts_pkg::ST_MUL_CUR:
            begin
                torque_next = mul_res;
                st_next     = dcmts_pkg::ST_DONE;
            end
            dcmts_pkg::ST_DONE:
            begin
                // The battery current is zero unless both the winding current and
                // its product with the level are positive.
                if (out_free)
                begin
                    out_torque_next = torque_reg;
                    out_lvl_next    = lvl_reg;
                    if ((im_reg > 0) && !mul_res[DW-1])
                    begin
                        out_cur_next = mul_res[RW-1:0];
                    end
                    else
                    begin
                        out_cur_next = '0;
                    end
                    out_valid_next = 1'b1;
                    st_next        = dcmts_pkg::ST_IDLE;
                end
            end
            default:
            begin
                st_next = dcmts_pkg::ST_IDLE;
            end
        endcase
    end

    assign result.valid           = out_valid_reg;
    assign result.torque_out      = out_torque_reg;
    assign result.battery_current = out_cur_reg;
    assign result.throttle_level  = out_lvl_reg;

endmodule
